@@ rtl/bse_pkg.sv @@
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bubble sort engine: transaction
// payloads and the sequencer states.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_set;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
        logic                     overflowed;
    } t_out_item;

    typedef enum logic [2:0] {
        S_LOAD,      // collect elements of a set
        S_FIRST,     // pick up element 0 as the running maximum of a pass
        S_CMP,       // compare running maximum with the next element
        S_WB,        // store the pass maximum at the end of the pass
        S_ORD,       // issue read of the next sorted element
        S_OLD        // move read data into the output register
    } t_state;

endpackage

@@ rtl/bubble_sort_engine_top.sv @@
// ----------------------------------------------------------------------------
// bubble_sort_engine_top
// Collects a set of signed values, sorts them ascending by bubble sort with
// one shared compare unit over a RAM, and streams the sorted set out.
//
//   channel   direction  handshake               payload
//   in        sink       i_in_valid/o_in_stall   i_in_data  (t_in_item)
//   out       source     o_out_valid/i_out_stall o_out_data (t_out_item)
//
// Loading accepts one element per cycle. A set then sorts in passes, one
// compare-swap per cycle within a pass through the single comparator and the
// RAM, and streams out with a RAM read, then an output register load, for each
// result, one result at a time. Reset is synchronous and clears the sequencer,
// the count, the overflow flag and the output valid; the RAM is not cleared.
// Input stall is high outside loading; output stall holds the output register
// and pauses the read-out.
// ----------------------------------------------------------------------------
module bubble_sort_engine_top #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bse_pkg::t_out_item o_out_data
);
    import bse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_ovf, n_ovf;
    logic [AW-1:0]            r_j, n_j;
    logic [AW-1:0]            r_pass_end, n_pass_end;
    logic [AW-1:0]            r_k, n_k;
    logic signed [DATA_W-1:0] r_carry, n_carry;
    t_out_item                r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rd_val;

    logic          in_acc;
    logic          full;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] count_m1;
    logic          gt;
    logic          pass_done;
    logic          out_free;
    logic          out_last;

    bse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val    = $signed(ram_rdata);
    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign full      = (r_count == CW'(DEPTH));
    assign count_inc = full ? r_count : r_count + CW'(1);
    assign count_m1  = count_inc - CW'(1);
    assign gt        = r_carry > rd_val;
    assign pass_done = (AW'(r_j + AW'(1)) == r_pass_end);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_last  = ((CW'(r_k) + CW'(1)) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_data.end_of_set) begin
                    n_state = (count_inc > CW'(1)) ? S_FIRST : S_ORD;
                end
            end
            S_FIRST: n_state = S_CMP;
            S_CMP: begin
                if (pass_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: n_state = (r_pass_end == AW'(1)) ? S_ORD : S_FIRST;
            S_ORD: begin
                if (out_free) begin
                    n_state = S_OLD;
                end
            end
            S_OLD: n_state = out_last ? S_LOAD : S_ORD;
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_j         = r_j;
        n_pass_end  = r_pass_end;
        n_k         = r_k;
        n_carry     = r_carry;
        n_out       = r_out;
        n_out_valid = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_j;
        ram_wdata   = r_carry;
        ram_raddr   = '0;
        case (r_state)
            S_LOAD: begin
                ram_waddr = r_count[AW-1:0];
                ram_wdata = i_in_data.value;
                if (in_acc) begin
                    ram_we  = !full;
                    n_count = count_inc;
                    n_ovf   = r_ovf | full;
                    if (i_in_data.end_of_set) begin
                        n_pass_end = count_m1[AW-1:0];
                        n_k        = '0;
                    end
                end
            end
            S_FIRST: begin
                n_carry   = rd_val;
                n_j       = '0;
                ram_raddr = AW'(1);
            end
            S_CMP: begin
                // keep the smaller in place, carry the larger forward
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = gt ? rd_val : r_carry;
                n_carry   = gt ? r_carry : rd_val;
                n_j       = AW'(r_j + AW'(1));
                ram_raddr = AW'(r_j + AW'(2));
            end
            S_WB: begin
                ram_we     = 1'b1;
                ram_waddr  = r_pass_end;
                ram_wdata  = r_carry;
                n_pass_end = AW'(r_pass_end - AW'(1));
                n_k        = '0;
            end
            S_ORD: begin
                ram_raddr = r_k;
            end
            S_OLD: begin
                ram_raddr         = r_k;
                n_out.sorted_value = rd_val;
                n_out.last_result  = out_last;
                n_out.overflowed   = r_ovf;
                n_out_valid        = 1'b1;
                n_k                = AW'(r_k + AW'(1));
                if (out_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_pass_end <= n_pass_end;
        r_k        <= n_k;
        r_carry    <= n_carry;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the output register is always empty when a result is loaded
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD) |-> !r_out_valid)
        else $error("result loaded over a pending transaction");

    // the final result returns the block to loading with a cleared set
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD && out_last) |=> (r_state == S_LOAD && r_count == '0 && !r_ovf))
        else $error("set not closed after final result");

    // sort writes stay inside the stored part of the set
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != S_LOAD) |-> (CW'(ram_waddr) < r_count))
        else $error("sort write outside the set");

    // a pass never reaches past the stored elements
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_WB) |-> (CW'(r_pass_end) < r_count))
        else $error("pass end beyond element count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above capacity");

endmodule

@@ rtl/bse_ram.sv @@
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
